/* design/e2r_pkg.sv */
package e2r_pkg;

  localparam int OUT_W = 16;
  localparam int FB    = OUT_W - 1;
  localparam int RSH   = (FB < 30) ? 30 - FB : 0;
  localparam int LSH   = (FB >= 30) ? FB - 30 : 0;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [18:0] RAD_PER_UNIT = 19'd292818;

  localparam logic [16:0] TURN_OFS = 17'd46080;
  localparam logic [16:0] TURN_1   = 17'd23040;
  localparam logic [16:0] TURN_2   = 17'd46080;
  localparam logic [16:0] TURN_3   = 17'd69120;
  localparam logic [14:0] QTR_1    = 15'd5760;
  localparam logic [14:0] QTR_2    = 15'd11520;
  localparam logic [14:0] QTR_3    = 15'd17280;
  localparam logic [12:0] QTR      = 13'd5760;
  localparam logic [12:0] EIGHTH   = 13'd2880;

  localparam int SIN_STEPS = 3;
  localparam int COS_STEPS = 4;

  // reciprocal m = ceil(2^k / d), k = 30 + ceil(log2 d); exact for 30-bit dividends
  localparam logic [30:0] SIN_RECIP [SIN_STEPS] = '{31'd1636178018, 31'd1717986919,
                                                    31'd1431655766};
  localparam logic [5:0]  SIN_SHIFT [SIN_STEPS] = '{6'd36, 6'd35, 6'd33};
  localparam logic [30:0] COS_RECIP [COS_STEPS] = '{31'd1227133514, 31'd1145324613,
                                                    31'd1431655766, 31'd1073741824};
  localparam logic [5:0]  COS_SHIFT [COS_STEPS] = '{6'd36, 6'd35, 6'd34, 6'd31};

  localparam int LANE_DEPTH = 13;
  localparam int PIPE_DEPTH = LANE_DEPTH + 3;

  typedef logic signed [OUT_W-1:0] out_t;

  typedef enum logic [1:0] {
    QuadI   = 2'd0,
    QuadII  = 2'd1,
    QuadIII = 2'd2,
    QuadIV  = 2'd3
  } quad_e;

  localparam logic [34:0] MAXV = (35'd1 << FB) - 35'd1;
  localparam logic [34:0] MINM = 35'd1 << FB;
  localparam logic [34:0] RND  = (35'd1 << RSH) >> 1;

  function automatic logic signed [31:0] q30_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] pr;
    logic [31:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 31'(-a) : 31'(a);
    mb  = b[31] ? 31'(-b) : 31'(b);
    pr  = 62'(ma) * 62'(mb) + 62'(32'h2000_0000);
    m   = pr[61:30];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic out_t to_out(input logic signed [32:0] e);
    logic        neg;
    logic [32:0] mag;
    logic [34:0] sc;
    logic [34:0] res;
    neg = e[32];
    mag = neg ? 33'(-e) : 33'(e);
    if (RSH > 0) begin
      sc = (35'(mag) + RND) >> RSH;
    end else begin
      sc = 35'(mag) << LSH;
    end
    if (!neg && sc > MAXV) begin
      res = MAXV;
    end else if (neg && sc > MINM) begin
      res = -MINM;
    end else begin
      res = neg ? -sc : sc;
    end
    return out_t'(res[OUT_W-1:0]);
  endfunction

endpackage

/* design/e2r_horner_cell.sv */
module e2r_horner_cell import e2r_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] t_i,
  input  logic [29:0] t2_i,
  input  logic [30:0] p_i,
  input  logic [30:0] recip_i,
  input  logic [5:0]  rshift_i,
  output logic [29:0] t_o,
  output logic [29:0] t2_o,
  output logic [30:0] p_o
);

  logic [60:0] prod_a;
  logic [60:0] prod_b;
  logic [60:0] quo;
  logic [29:0] v_q;
  logic [29:0] ta_q, t2a_q;
  logic [29:0] tb_q, t2b_q;
  logic [30:0] p_d, p_q;

  assign prod_a = 61'(t2_i) * 61'(p_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= prod_a[59:30];
      ta_q  <= t_i;
      t2a_q <= t2_i;
    end
  end

  assign prod_b = 61'(v_q) * 61'(recip_i);
  assign quo    = prod_b >> rshift_i;
  assign p_d    = Q30_ONE - quo[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      tb_q  <= ta_q;
      t2b_q <= t2a_q;
    end
  end

  assign t_o  = tb_q;
  assign t2_o = t2b_q;
  assign p_o  = p_q;

endmodule

/* design/e2r_trig_lane.sv */
module e2r_trig_lane import e2r_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic [16:0] a;
  logic [14:0] u_d, u_q;
  quad_e       quad_d;
  logic [12:0] xr;
  logic [11:0] xp_d, xp_q;
  logic        swap_d;
  quad_e       quad_q [11];
  logic        swap_q [11];
  logic [29:0] t_q, t4_q, t2_q;
  logic [29:0] prod_t;
  logic [59:0] sq;
  logic [29:0] st_w  [SIN_STEPS+1];
  logic [29:0] st2_w [SIN_STEPS+1];
  logic [30:0] sp_w  [SIN_STEPS+1];
  logic [29:0] ct_w  [COS_STEPS+1];
  logic [29:0] ct2_w [COS_STEPS+1];
  logic [30:0] cp_w  [COS_STEPS+1];
  logic [60:0] sprod;
  logic [30:0] s_q, s_dly_q;
  logic [31:0] s0, c0;
  logic signed [31:0] sin_d, cos_d, sin_q, cos_q;

  // turn reduction
  assign a = {angle_i[15], angle_i} + TURN_OFS;

  always_comb begin
    if (a >= TURN_3) begin
      u_d = 15'(a - TURN_3);
    end else if (a >= TURN_2) begin
      u_d = 15'(a - TURN_2);
    end else if (a >= TURN_1) begin
      u_d = 15'(a - TURN_1);
    end else begin
      u_d = a[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q <= u_d;
    end
  end

  // quadrant and octant fold
  always_comb begin
    if (u_q >= QTR_3) begin
      quad_d = QuadIV;
      xr     = 13'(u_q - QTR_3);
    end else if (u_q >= QTR_2) begin
      quad_d = QuadIII;
      xr     = 13'(u_q - QTR_2);
    end else if (u_q >= QTR_1) begin
      quad_d = QuadII;
      xr     = 13'(u_q - QTR_1);
    end else begin
      quad_d = QuadI;
      xr     = u_q[12:0];
    end
    swap_d = xr > EIGHTH;
    xp_d   = swap_d ? 12'(QTR - xr) : xr[11:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q      <= xp_d;
      quad_q[0] <= quad_d;
      swap_q[0] <= swap_d;
      for (int i = 1; i < 11; i++) begin
        quad_q[i] <= quad_q[i-1];
        swap_q[i] <= swap_q[i-1];
      end
    end
  end

  assign prod_t = 30'(xp_q) * 30'(RAD_PER_UNIT);
  assign sq     = 60'(t_q) * 60'(t_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= prod_t;
      t4_q <= t_q;
      t2_q <= sq[59:30];
    end
  end

  assign st_w[0]  = t4_q;
  assign st2_w[0] = t2_q;
  assign sp_w[0]  = Q30_ONE;
  assign ct_w[0]  = t4_q;
  assign ct2_w[0] = t2_q;
  assign cp_w[0]  = Q30_ONE;

  for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
    e2r_horner_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (en_i),
      .t_i      (st_w[g]),
      .t2_i     (st2_w[g]),
      .p_i      (sp_w[g]),
      .recip_i  (SIN_RECIP[g]),
      .rshift_i (SIN_SHIFT[g]),
      .t_o      (st_w[g+1]),
      .t2_o     (st2_w[g+1]),
      .p_o      (sp_w[g+1])
    );
  end

  for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
    e2r_horner_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (en_i),
      .t_i      (ct_w[g]),
      .t2_i     (ct2_w[g]),
      .p_i      (cp_w[g]),
      .recip_i  (COS_RECIP[g]),
      .rshift_i (COS_SHIFT[g]),
      .t_o      (ct_w[g+1]),
      .t2_o     (ct2_w[g+1]),
      .p_o      (cp_w[g+1])
    );
  end

  assign sprod = 61'(st_w[SIN_STEPS]) * 61'(sp_w[SIN_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= {1'b0, sprod[59:30]};
      s_dly_q <= s_q;
    end
  end

  always_comb begin
    s0 = swap_q[10] ? {1'b0, cp_w[COS_STEPS]} : {1'b0, s_dly_q};
    c0 = swap_q[10] ? {1'b0, s_dly_q} : {1'b0, cp_w[COS_STEPS]};
    case (quad_q[10])
      QuadI: begin
        sin_d = $signed(s0);
        cos_d = $signed(c0);
      end
      QuadII: begin
        sin_d = $signed(c0);
        cos_d = -$signed(s0);
      end
      QuadIII: begin
        sin_d = -$signed(s0);
        cos_d = -$signed(c0);
      end
      default: begin
        sin_d = -$signed(c0);
        cos_d = $signed(s0);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* design/e2r_matrix.sv */
module e2r_matrix import e2r_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sr_i,
  input  logic signed [31:0] cr_i,
  input  logic signed [31:0] sp_i,
  input  logic signed [31:0] cp_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  output out_t               m_o [9]
);

  logic signed [31:0] spsr_q, spcr_q, crcy_q, crsy_q, cpsr_q, cpsy_q;
  logic signed [31:0] cpcy_q, srsy_q, srcy_q, cpcr_q, sp_q, sy_q, cy_q;
  logic signed [32:0] e_d [9];
  logic signed [32:0] e_q [9];
  out_t               m_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spsr_q <= q30_mul(sp_i, sr_i);
      spcr_q <= q30_mul(sp_i, cr_i);
      crcy_q <= q30_mul(cr_i, cy_i);
      crsy_q <= q30_mul(cr_i, sy_i);
      cpsr_q <= q30_mul(cp_i, sr_i);
      cpsy_q <= q30_mul(cp_i, sy_i);
      cpcy_q <= q30_mul(cp_i, cy_i);
      srsy_q <= q30_mul(sr_i, sy_i);
      srcy_q <= q30_mul(sr_i, cy_i);
      cpcr_q <= q30_mul(cp_i, cr_i);
      sp_q   <= sp_i;
      sy_q   <= sy_i;
      cy_q   <= cy_i;
    end
  end

  always_comb begin
    e_d[0] = 33'(crcy_q) - 33'(q30_mul(spsr_q, sy_q));
    e_d[1] = 33'(q30_mul(spsr_q, cy_q)) + 33'(crsy_q);
    e_d[2] = -33'(cpsr_q);
    e_d[3] = -33'(cpsy_q);
    e_d[4] = 33'(cpcy_q);
    e_d[5] = 33'(sp_q);
    e_d[6] = 33'(q30_mul(spcr_q, sy_q)) + 33'(srcy_q);
    e_d[7] = 33'(srsy_q) - 33'(q30_mul(spcr_q, cy_q));
    e_d[8] = 33'(cpcr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= to_out(e_q[i]);
      end
    end
  end

  assign m_o = m_q;

endmodule

/* design/euler_to_rotation_matrix_core.sv */
// Euler angles to 3x3 rotation matrix.
// Input channel: valid_i / stall_o with roll, pitch and yaw angles in signed
// 1/64 degree units; a beat is taken on a clock edge with valid_i high and
// stall_o low.
// Output channel: valid_o / stall_i with the nine matrix entries m00..m22 in
// signed Q1.15, +1.0 saturating to the largest code.
// One beat per cycle is sustained while the receiver does not stall. The
// pipeline depth is set by the sine/cosine chain: turn reduction,
// quadrant fold, angle scaling and squaring (four registers), four Horner
// cells for cosine at two registers each (the three sine cells finish
// earlier and wait), the quadrant select register, then two product stages
// and the output rounding register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// stall_o rises in the same cycle; otherwise a new beat enters every cycle,
// also while the last stage is being handed over.
// Reset empties the pipeline valid bits; no result is pending afterwards.
module euler_to_rotation_matrix_core import e2r_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  output logic               valid_o,
  input  logic               stall_i,
  output out_t               m00_o,
  output out_t               m01_o,
  output out_t               m02_o,
  output out_t               m10_o,
  output out_t               m11_o,
  output out_t               m12_o,
  output out_t               m20_o,
  output out_t               m21_o,
  output out_t               m22_o
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic signed [31:0]    sr, cr, sp, cp, sy, cy;
  out_t                  m [9];

  assign en      = !(vld_q[PIPE_DEPTH-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], valid_i};
    end
  end

  e2r_trig_lane u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (roll_angle_i),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  e2r_trig_lane u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (pitch_angle_i),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  e2r_trig_lane u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (yaw_angle_i),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  e2r_matrix u_matrix (
    .clk_i (clk_i),
    .en_i  (en),
    .sr_i  (sr),
    .cr_i  (cr),
    .sp_i  (sp),
    .cp_i  (cp),
    .sy_i  (sy),
    .cy_i  (cy),
    .m_o   (m)
  );

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

`ifndef SYNTH
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[0])
    else $error("accepted beat not in first stage");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_DEPTH-1] && stall_i) |=> vld_q[PIPE_DEPTH-1])
    else $error("stalled result lost");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[PIPE_DEPTH-2]) |=> vld_q[PIPE_DEPTH-1])
    else $error("beat dropped before output stage");
`endif

endmodule
